[src/tdm_pkg.sv]
`timescale 1ns / 1ps

package tdm_pkg;

	// Default memory size in bytes
	localparam int MEM_BYTES_DEF = 4096;

	// Byte lanes: one bank per byte of a double word
	localparam int NUM_BANKS = 8;
	localparam int LANE_W    = 3;

	// Access sizes
	localparam logic [1:0] SZ_BYTE   = 2'd0;
	localparam logic [1:0] SZ_HALF   = 2'd1;
	localparam logic [1:0] SZ_WORD   = 2'd2;
	localparam logic [1:0] SZ_DOUBLE = 2'd3;

	// Actions
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_UNWRITTEN  = 2'd1;
	localparam logic [1:0] ST_MISALIGNED = 2'd2;
	localparam logic [1:0] ST_RANGE      = 2'd3;

	// Bank entry: stored byte plus its written mark
	typedef struct packed {
		logic       mark;
		logic [7:0] data;
	} bank_entry_t;

endpackage

[src/tdm_ram.sv]
`timescale 1ns / 1ps

module tdm_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/tracked_data_memory_top.sv]
`timescale 1ns / 1ps
// A beat passes stage 1, then enters the output register once that is free.
// Throughput: one access per cycle while in_stall is low; the eight byte-lane banks
// are each read or written once per access, so unaligned accesses are not split.
// Reset: check_reads returns to 1 and a clearing pass writes zero to every bank row,
// all (MEM_BYTES+7)/8 of them (512 at the default size), while the input stays stalled.

module tracked_data_memory_top
	import tdm_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [1:0]  access_size,
	input  logic [11:0] address,
	input  logic [63:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] read_data,
	output logic [1:0]  result_status
);

	localparam int DEPTH = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
	localparam int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $bits(bank_entry_t);

	// Control and configuration
	logic             check_reads_q;
	logic             clearing_q;
	logic [ROW_W-1:0] clr_row_q;
	logic             v_s1;
	logic             out_valid_q;
	logic             out_load;
	logic             s1_adv;
	logic             accept;

	// Stage 1 payload
	logic             write_s1;
	logic [1:0]       size_s1;
	logic [LANE_W-1:0] lane_s1;
	logic             oor_s1;
	logic             chk_s1;

	// Output register payload
	logic [63:0]      rdata_q;
	logic [1:0]       status_q;

	// Bank ports
	logic             bank_we    [NUM_BANKS];
	logic [ROW_W-1:0] bank_row   [NUM_BANKS];
	bank_entry_t      bank_wdata [NUM_BANKS];
	logic [EW-1:0]    bank_rdata [NUM_BANKS];
	logic             bank_re;

	// Address decode at accept
	logic [3:0]        nbytes;
	logic [12:0]       end_addr;
	logic              oor;
	logic [8:0]        row0;
	logic [9:0]        row1;
	logic [LANE_W-1:0] lane0;

	// Stage 1 evaluation
	logic [63:0] rd_val;
	logic        unwritten;
	logic        misaligned;
	logic [1:0]  status_s1;
	logic [63:0] data_s1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_reads_q <= 1'b1;
		end else if (cfg_wr_en) begin
			check_reads_q <= cfg_wr_data;
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			if (clr_row_q == ROW_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	// Handshake: s1 moves into the output register when that register is free
	assign out_load = !out_valid_q || !out_stall;
	assign s1_adv   = v_s1 && out_load;
	assign in_stall = clearing_q || (v_s1 && !out_load);
	assign accept   = in_valid && !in_stall;

	// Decode the incoming beat
	always_comb begin
		nbytes   = 4'd1 << access_size;
		end_addr = {1'b0, address} + 13'(nbytes);
		oor      = 32'(end_addr) > 32'(MEM_BYTES);
		row0     = address[11:3];
		row1     = {1'b0, row0} + 10'd1;
		lane0    = address[2:0];
	end

	// Bank addressing, write enables and write data
	always_comb begin
		logic [LANE_W-1:0] k;
		bank_re = accept && (action == ACT_READ) && !oor;
		for (int b = 0; b < NUM_BANKS; b++) begin
			k = LANE_W'(b) - lane0;
			if (clearing_q) begin
				bank_row[b]   = clr_row_q;
				bank_we[b]    = 1'b1;
				bank_wdata[b] = '0;
			end else begin
				bank_row[b]        = (LANE_W'(b) >= lane0) ? ROW_W'(row0) : ROW_W'(row1);
				bank_we[b]         = accept && (action == ACT_WRITE) && !oor
				                     && ({1'b0, k} < nbytes);
				bank_wdata[b].mark = 1'b1;
				bank_wdata[b].data = write_data[8*k +: 8];
			end
		end
	end

	// Byte-lane banks
	for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
		tdm_ram #(
			.WIDTH (EW),
			.DEPTH (DEPTH),
			.AW    (ROW_W)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.waddr (bank_row[g]),
			.wdata (bank_wdata[g]),
			.re    (bank_re),
			.raddr (bank_row[g]),
			.rdata (bank_rdata[g])
		);
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1 <= action;
			size_s1  <= access_size;
			lane_s1  <= lane0;
			oor_s1   <= oor;
			chk_s1   <= (access_size != SZ_DOUBLE) || check_reads_q;
		end
	end

	// Rotate bank outputs into byte order, check marks and alignment
	always_comb begin
		logic [3:0]        n;
		logic [LANE_W-1:0] idx;
		bank_entry_t       ent;
		n          = 4'd1 << size_s1;
		rd_val     = '0;
		unwritten  = 1'b0;
		for (int k = 0; k < NUM_BANKS; k++) begin
			idx = lane_s1 + LANE_W'(k);
			ent = bank_entry_t'(bank_rdata[idx]);
			if (4'(k) < n) begin
				rd_val[8*k +: 8] = ent.data;
				if (!ent.mark) begin
					unwritten = 1'b1;
				end
			end
		end
		misaligned = (lane_s1 & LANE_W'(n - 4'd1)) != '0;
		data_s1    = '0;
		if (oor_s1) begin
			status_s1 = ST_RANGE;
		end else if (write_s1 == ACT_WRITE) begin
			status_s1 = ST_OK;
		end else if (chk_s1 && unwritten) begin
			status_s1 = ST_UNWRITTEN;
		end else if (misaligned) begin
			status_s1 = ST_MISALIGNED;
		end else begin
			status_s1 = ST_OK;
			data_s1   = rd_val;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rdata_q  <= data_s1;
			status_q <= status_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = rdata_q;
	assign result_status = status_q;

`ifndef SYNTHESIS
	// No beat is in flight while the clearing pass runs
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (!v_s1 && !out_valid_q))
		else $error("beat in flight during clearing pass");

	// Any error status carries zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_status != ST_OK)) |-> (read_data == 64'd0))
		else $error("nonzero data with error status");

	// A new result only follows a beat held in stage 1
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s1))
		else $error("result without stage 1 beat");

	// A stalled stage 1 beat blocks further input
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && out_stall) |-> in_stall)
		else $error("input taken while stage 1 stalled");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import tdm_pkg::*;

	// Expected outcome of one access
	typedef struct packed {
		logic [63:0] data;
		logic [1:0]  status;
	} access_result_t;

	// Shadow copy of the byte store and its written marks; queues one
	// expected result per accepted access and checks results in order.
	class memory_shadow;
		bit [7:0]       mem_bytes [MEM_BYTES_DEF];
		bit             written [MEM_BYTES_DEF];
		bit             check_doubles = 1'b1;
		access_result_t pending_results [$];
		int             errors;

		function void record_access(logic act, logic [1:0] sz, logic [11:0] addr,
				logic [63:0] wdata);
			access_result_t r;
			int nbytes;
			r.data = '0;
			r.status = ST_OK;
			nbytes = 1 << sz;
			if (int'(addr) + nbytes > MEM_BYTES_DEF) begin
				// past the end: status only, writes dropped
				r.status = ST_RANGE;
			end else if (act == ACT_WRITE) begin
				for (int i = 0; i < nbytes; i++) begin
					mem_bytes[int'(addr) + i] = wdata[8*i +: 8];
					written[int'(addr) + i] = 1'b1;
				end
			end else begin
				// written check first, skipped for doubles when disabled
				if (sz != SZ_DOUBLE || check_doubles) begin
					for (int i = 0; i < nbytes; i++)
						if (!written[int'(addr) + i])
							r.status = ST_UNWRITTEN;
				end
				if (r.status == ST_OK && (int'(addr) & (nbytes - 1)) != 0)
					r.status = ST_MISALIGNED;
				if (r.status == ST_OK)
					for (int i = 0; i < nbytes; i++)
						r.data[8*i +: 8] = mem_bytes[int'(addr) + i];
			end
			pending_results.push_back(r);
		endfunction

		function void compare_result(logic [63:0] data, logic [1:0] status);
			access_result_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending: read_data %h result_status %0d",
					data, status);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (data !== exp_r.data) begin
				$error("read_data: expected %h, actual %h", exp_r.data, data);
				errors++;
			end
			if (status !== exp_r.status) begin
				$error("result_status: expected %0d, actual %0d", exp_r.status, status);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = ACT_READ;
	logic [1:0]  access_size = SZ_BYTE;
	logic [11:0] address = '0;
	logic [63:0] write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] read_data;
	logic [1:0]  result_status;

	memory_shadow shadow = new();

	tracked_data_memory_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.access_size  (access_size),
		.address      (address),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.result_status(result_status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watch both channels and the config port at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				shadow.check_doubles = cfg_wr_data;
			if (in_valid && !in_stall)
				shadow.record_access(action, access_size, address, write_data);
			if (out_valid && !out_stall)
				shadow.compare_result(read_data, result_status);
		end
	end

	// Result side: stall at a random rate that is redrawn after each random span
	int stall_rate = 0;
	int stall_span = 0;
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(200, 20);
			case ($urandom_range(3))
				0: stall_rate = 0;
				1: stall_rate = 20;
				2: stall_rate = 50;
				default: stall_rate = 90;
			endcase
		end else begin
			stall_span = stall_span - 1;
		end
		out_stall <= ($urandom_range(99) < stall_rate);
	end

	// Present one access and hold it until accepted
	task automatic drive_access(logic act, logic [1:0] sz, logic [11:0] addr,
			logic [63:0] wdata);
		in_valid <= 1'b1;
		action <= act;
		access_size <= sz;
		address <= addr;
		write_data <= wdata;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off input until every pending result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending_results.size() != 0);
	endtask

	task automatic write_check_reads(logic value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random access: mostly small windows so reads hit written bytes
	task automatic random_access();
		logic        act;
		logic [1:0]  sz;
		logic [11:0] addr;
		logic [63:0] wdata;
		int          pick;
		act = ($urandom_range(99) < 40) ? ACT_WRITE : ACT_READ;
		sz = 2'($urandom_range(3));
		wdata = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 60)
			addr = 12'(($urandom_range(1) ? 12'hF00 : 12'h000) + $urandom_range(127));
		else if (pick < 85)
			addr = 12'(12'hFF0 + $urandom_range(15));
		else
			addr = 12'($urandom_range(4095));
		if (pick < 85 && $urandom_range(99) < 70)
			addr = addr & ~12'((1 << sz) - 1);
		drive_access(act, sz, addr, wdata);
	endtask

	initial begin
		int items_left;
		int burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: edges of the address range, each size, each error
		drive_access(ACT_READ,  SZ_BYTE,   12'h000, 64'h0);
		drive_access(ACT_WRITE, SZ_DOUBLE, 12'h000, 64'hFFFF_FFFF_FFFF_FFFF);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'h000, 64'h0);
		drive_access(ACT_WRITE, SZ_BYTE,   12'hFFF, 64'h0000_0000_0000_00A5);
		drive_access(ACT_READ,  SZ_BYTE,   12'hFFF, 64'h0);
		drive_access(ACT_WRITE, SZ_HALF,   12'hFFF, 64'h5A5A_5A5A_5A5A_5A5A);
		drive_access(ACT_READ,  SZ_HALF,   12'hFFF, 64'h0);
		drive_access(ACT_WRITE, SZ_WORD,   12'hFFD, 64'h1111_2222_3333_4444);
		drive_access(ACT_WRITE, SZ_WORD,   12'hFF8, 64'h1111_2222_3333_4444);
		drive_access(ACT_READ,  SZ_WORD,   12'hFF8, 64'h0);
		drive_access(ACT_WRITE, SZ_DOUBLE, 12'hFF9, 64'hDEAD_BEEF_0BAD_F00D);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'hFF9, 64'h0);
		drive_access(ACT_WRITE, SZ_HALF,   12'h011, 64'hFFFF_FFFF_FFFF_1234);
		drive_access(ACT_READ,  SZ_HALF,   12'h011, 64'h0);
		drive_access(ACT_READ,  SZ_WORD,   12'h011, 64'h0);
		drive_access(ACT_READ,  SZ_HALF,   12'h012, 64'h0);
		drive_access(ACT_WRITE, SZ_WORD,   12'h020, 64'h0);
		drive_access(ACT_READ,  SZ_WORD,   12'h020, 64'h0);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'h008, 64'h0);
		drain_results();

		// Unchecked doubles: vacant bytes read as stored, alignment still checked
		write_check_reads(1'b0);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'h100, 64'h0);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'h004, 64'h0);
		drive_access(ACT_READ,  SZ_WORD,   12'h100, 64'h0);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'h000, 64'h0);
		drive_access(ACT_READ,  SZ_DOUBLE, 12'hFF8, 64'h0);

		// Random phases, each behind a drain and a config write
		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			write_check_reads(phase == 3 ? logic'($urandom_range(1)) : logic'(phase % 2 == 0));
			items_left = 305;
			while (items_left > 0) begin
				burst = ($urandom_range(9) == 0) ? 150 : $urandom_range(40, 1);
				for (int j = 0; j < burst && items_left > 0; j++) begin
					random_access();
					items_left--;
				end
				if ($urandom_range(3) != 0)
					idle_sender($urandom_range(12, 1));
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending_results.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
